### rtl/drf_pkg.sv
// package for the delimited frame reassembler
// holds status codes, register indexes, reset values and fixed widths
`timescale 1ns / 1ps

package drf_pkg;

  localparam int ByteW = 8;
  localparam int StatusW = 3;
  localparam int RemW = 9;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 8;

  localparam int MaxFragmentBytes = 512;
  localparam int MinFragmentBytes = 3;
  localparam int LengthBias = 3;

  localparam logic [ByteW-1:0] StartMarkerReset = 8'h60;
  localparam logic [ByteW-1:0] EndMarkerReset = 8'h61;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartMarker = 1'b0,
    CfgEndMarker   = 1'b1
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    StProgress = 3'd0,
    StComplete = 3'd1,
    StWaiting  = 3'd2,
    StShort    = 3'd3,
    StBadStart = 3'd4,
    StBadEnd   = 3'd5
  } status_e;

endpackage

### rtl/drf_if.sv
// valid/ready channel interfaces for the delimited frame reassembler
// fragment byte channel and result channel; depends on drf_pkg
`timescale 1ns / 1ps

interface drf_in_if;
  logic                      valid;
  logic                      ready;
  logic [drf_pkg::ByteW-1:0] data_byte;
  logic                      fragment_end;

  modport source (output valid, output data_byte, output fragment_end, input ready);
  modport sink (input valid, input data_byte, input fragment_end, output ready);
endinterface

interface drf_out_if;
  logic                        valid;
  logic                        ready;
  logic [drf_pkg::ByteW-1:0]   out_byte;
  logic                        at_fragment_end;
  logic                        message_end;
  logic [drf_pkg::StatusW-1:0] status;

  modport source (output valid, output out_byte, output at_fragment_end,
                  output message_end, output status, input ready);
  modport sink (input valid, input out_byte, input at_fragment_end,
                input message_end, input status, output ready);
endinterface

### rtl/delimited_frame_reassembler.sv
// delimited frame reassembler top level
// uses drf_pkg and the channel interfaces in drf_if.sv
`timescale 1ns / 1ps

// Usage: fragment bytes enter on in_i, one request per byte, with
// fragment_end set on the last byte of each fragment. Every byte leaves on
// out_o as one result request carrying the byte, a fragment-end flag, a
// message-end flag and a status code (final only on fragment ends).
// The start and end markers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i while the block is idle.
// Latency: a result is valid in the cycle after its byte is taken.
// Throughput: one byte per cycle unless out_o stalls; the header checks and
// the remaining-count update are single compares and one subtract ahead of
// the result register. in_i.ready stays high while the result register is
// empty or being taken, so a stalled receiver holds the result and blocks
// only the next byte. Reset clears the reassembly state, empties the result
// register and loads the default markers.

module delimited_frame_reassembler #(
  parameter int MAX_FRAGMENT_BYTES = drf_pkg::MaxFragmentBytes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [drf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [drf_pkg::CfgDataW-1:0] cfg_data_i,
  drf_in_if.sink                       in_i,
  drf_out_if.source                    out_o
);

  localparam int CntW = $clog2(MAX_FRAGMENT_BYTES + 1);
  localparam int CmpW = (CntW > drf_pkg::RemW) ? CntW : drf_pkg::RemW;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAGMENT_BYTES);

  logic [drf_pkg::ByteW-1:0] start_marker_q, end_marker_q;

  logic                      in_cont_q, in_cont_d;
  logic [drf_pkg::RemW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]           frag_cnt_q, frag_cnt_d;
  logic                      first_ok_q, first_ok_d;
  logic [drf_pkg::ByteW-1:0] len_q, len_d;

  logic                      out_valid_q;
  logic [drf_pkg::ByteW-1:0] out_byte_q;
  logic                      out_last_q, out_msg_end_q;
  drf_pkg::status_e          out_status_q, status_d;

  logic                      in_fire;
  logic [CntW-1:0]           cnt_inc;
  logic [CmpW-1:0]           size_ext, rem_ext, msg_ext;
  logic [drf_pkg::RemW-1:0]  msg_len, rem_sub, rem_new;
  logic                      end_ok;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= drf_pkg::StartMarkerReset;
      end_marker_q   <= drf_pkg::EndMarkerReset;
    end else if (cfg_we_i) begin
      unique case (drf_pkg::cfg_idx_e'(cfg_idx_i))
        drf_pkg::CfgStartMarker: start_marker_q <= cfg_data_i;
        drf_pkg::CfgEndMarker:   end_marker_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    first_ok_d = (frag_cnt_q == '0) ? (in_i.data_byte == start_marker_q) : first_ok_q;
    len_d      = (frag_cnt_q == CntW'(1)) ? in_i.data_byte : len_q;
    cnt_inc    = (frag_cnt_q < CntMax) ? frag_cnt_q + CntW'(1) : frag_cnt_q;

    size_ext = CmpW'(cnt_inc);
    rem_ext  = CmpW'(rem_q);
    msg_len  = drf_pkg::RemW'(len_d) + drf_pkg::RemW'(drf_pkg::LengthBias);
    msg_ext  = CmpW'(msg_len);
    rem_sub  = drf_pkg::RemW'(rem_ext - size_ext);
    rem_new  = drf_pkg::RemW'(msg_ext - size_ext);
    end_ok   = (in_i.data_byte == end_marker_q);

    in_cont_d  = in_cont_q;
    rem_d      = rem_q;
    frag_cnt_d = cnt_inc;
    status_d   = drf_pkg::StProgress;

    if (in_i.fragment_end) begin
      frag_cnt_d = '0;
      first_ok_d = 1'b0;
      len_d      = '0;
      if (in_cont_q) begin
        if (rem_ext <= size_ext) begin
          rem_d     = '0;
          in_cont_d = 1'b0;
          status_d  = end_ok ? drf_pkg::StComplete : drf_pkg::StBadEnd;
        end else begin
          rem_d    = rem_sub;
          status_d = drf_pkg::StWaiting;
        end
      end else if (size_ext < CmpW'(drf_pkg::MinFragmentBytes)) begin
        status_d = drf_pkg::StShort;
      end else if (!first_ok_q) begin
        status_d = drf_pkg::StBadStart;
      end else if (msg_ext > size_ext) begin
        in_cont_d = 1'b1;
        rem_d     = rem_new;
        status_d  = drf_pkg::StWaiting;
      end else begin
        status_d = end_ok ? drf_pkg::StComplete : drf_pkg::StBadEnd;
      end
    end
  end

  // reassembly state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cont_q  <= 1'b0;
      rem_q      <= '0;
      frag_cnt_q <= '0;
      first_ok_q <= 1'b0;
      len_q      <= '0;
    end else if (in_fire) begin
      in_cont_q  <= in_cont_d;
      rem_q      <= rem_d;
      frag_cnt_q <= frag_cnt_d;
      first_ok_q <= first_ok_d;
      len_q      <= len_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_byte_q    <= in_i.data_byte;
      out_last_q    <= in_i.fragment_end;
      out_msg_end_q <= (status_d == drf_pkg::StComplete);
      out_status_q  <= status_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.out_byte        = out_byte_q;
  assign out_o.at_fragment_end = out_last_q;
  assign out_o.message_end     = out_msg_end_q;
  assign out_o.status          = out_status_q;

  a_msg_end_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_msg_end_q |-> out_last_q && (out_status_q == drf_pkg::StComplete))
    else $error("message end without complete status");

  a_status_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_last_q == (out_status_q != drf_pkg::StProgress)))
    else $error("final status not aligned with fragment end");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.fragment_end |=> (frag_cnt_q == '0) && !first_ok_q)
    else $error("fragment state not cleared after fragment end");

  a_cont_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_cont_q |-> (rem_q != '0))
    else $error("continuation with nothing remaining");

endmodule
